/* hw/rtl/tsc_pkg.sv */
// Shared constants, types and register codes for the triangle/sphere classifier.
package tsc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam int SUM_W       = SQ_W + 2;
  localparam int DOT_W       = 2 * DIFF_W + 2;
  localparam int HALF_W      = SUM_W / 2;
  localparam int PROD_W      = 2 * SUM_W;
  localparam int RAD_W       = COORD_WIDTH - 1;
  localparam int R2_W        = 2 * RAD_W;
  localparam int NUM_STAGES  = 8;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(4096);

  typedef logic signed [COORD_WIDTH-1:0] tsc_coord_t;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } tsc_reg_e;

  typedef enum logic [1:0] {
    CLASS_OUTSIDE  = 2'd0,
    CLASS_CROSSING = 2'd1,
    CLASS_INSIDE   = 2'd2
  } tsc_class_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } tsc_front_en_t;

  typedef struct packed {
    logic sa;
    logic sb;
    logic sc;
  } tsc_mul_en_t;

endpackage

/* hw/rtl/tsc_if.sv */
// Valid/ready channel interfaces for triangle input and class output.
interface tsc_in_if import tsc_pkg::*; ();
  logic       valid;
  logic       ready;
  tsc_coord_t v0_x;
  tsc_coord_t v0_y;
  tsc_coord_t v0_z;
  tsc_coord_t v1_x;
  tsc_coord_t v1_y;
  tsc_coord_t v1_z;
  tsc_coord_t v2_x;
  tsc_coord_t v2_y;
  tsc_coord_t v2_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    output ready
  );
endinterface

interface tsc_out_if import tsc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] coverage_class;

  modport source (output valid, coverage_class, input ready);
  modport sink (input valid, coverage_class, output ready);
endinterface

/* hw/rtl/tsc_cfg.sv */
// APB register file holding sphere centre and radius, with the squared radius.
module tsc_cfg import tsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output tsc_coord_t         ctr_o [3],
  output logic [R2_W-1:0]    r2_o
);

  tsc_coord_t       cx_q, cy_q, cz_q;
  logic [RAD_W-1:0] rad_q;
  logic [R2_W-1:0]  r2_q, r2_d;
  logic             wr_en;
  tsc_reg_e         reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = tsc_reg_e'(paddr[PADDR_W-1:2]);
  assign r2_d    = R2_W'(rad_q) * R2_W'(rad_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= RADIUS_RESET;
      r2_q  <= R2_W'(RADIUS_RESET) * R2_W'(RADIUS_RESET);
    end else begin
      r2_q <= r2_d;
      if (wr_en) begin
        unique case (reg_idx)
          REG_CENTER_X: cx_q  <= pwdata[COORD_WIDTH-1:0];
          REG_CENTER_Y: cy_q  <= pwdata[COORD_WIDTH-1:0];
          REG_CENTER_Z: cz_q  <= pwdata[COORD_WIDTH-1:0];
          REG_RADIUS:   rad_q <= pwdata[RAD_W-1:0];
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = PDATA_W'(cx_q);
      REG_CENTER_Y: prdata = PDATA_W'(cy_q);
      REG_CENTER_Z: prdata = PDATA_W'(cz_q);
      REG_RADIUS:   prdata = PDATA_W'(rad_q);
    endcase
  end

  assign pready   = 1'b1;
  assign ctr_o[0] = cx_q;
  assign ctr_o[1] = cy_q;
  assign ctr_o[2] = cz_q;
  assign r2_o     = r2_q;

endmodule

/* hw/rtl/tsc_front.sv */
// Front stages: offsets and edges, exact products, sums, vertex and projection tests.
module tsc_front import tsc_pkg::*; (
  input  logic               clk_i,
  input  tsc_front_en_t      en_i,
  input  tsc_coord_t         p_i [3][3],
  input  tsc_coord_t         ctr_i [3],
  input  logic [R2_W-1:0]    r2_i,
  output logic [SUM_W-1:0]   excess_o [3],
  output logic [SUM_W-1:0]   len_o [3],
  output logic [SUM_W-1:0]   k_o [3],
  output logic [2:0]         hit_o,
  output logic [2:0]         kv_o
);

  logic signed [DIFF_W-1:0]   d_q [3][3];
  logic signed [DIFF_W-1:0]   e_q [3][3];
  logic signed [2*DIFF_W-1:0] dd_full [3][3];
  logic signed [2*DIFF_W-1:0] ee_full [3][3];
  logic signed [2*DIFF_W-1:0] ed_full [3][3];
  logic [SQ_W-1:0]            dsq_q [3][3];
  logic [SQ_W-1:0]            esq_q [3][3];
  logic signed [2*DIFF_W-1:0] dot_q [3][3];
  logic [SUM_W-1:0]           dist2_q [3];
  logic [SUM_W-1:0]           len3_q [3];
  logic signed [DOT_W-1:0]    kdot_q [3];
  logic [SUM_W-1:0]           r2_ext;
  logic [SUM_W-1:0]           exc_q [3];
  logic [SUM_W-1:0]           len4_q [3];
  logic [SUM_W-1:0]           k4_q [3];
  logic [2:0]                 hit_q, kv_q;

  assign r2_ext = SUM_W'(r2_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int i = 0; i < 3; i++) begin
        for (int a = 0; a < 3; a++) begin
          d_q[i][a] <= DIFF_W'(ctr_i[a]) - DIFF_W'(p_i[i][a]);
          e_q[i][a] <= DIFF_W'(p_i[(i + 1) % 3][a]) - DIFF_W'(p_i[i][a]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) begin
        dd_full[i][a] = d_q[i][a] * d_q[i][a];
        ee_full[i][a] = e_q[i][a] * e_q[i][a];
        ed_full[i][a] = e_q[i][a] * d_q[i][a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int i = 0; i < 3; i++) begin
        for (int a = 0; a < 3; a++) begin
          dsq_q[i][a] <= dd_full[i][a][SQ_W-1:0];
          esq_q[i][a] <= ee_full[i][a][SQ_W-1:0];
          dot_q[i][a] <= ed_full[i][a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int i = 0; i < 3; i++) begin
        dist2_q[i] <= SUM_W'(dsq_q[i][0]) + SUM_W'(dsq_q[i][1]) + SUM_W'(dsq_q[i][2]);
        len3_q[i]  <= SUM_W'(esq_q[i][0]) + SUM_W'(esq_q[i][1]) + SUM_W'(esq_q[i][2]);
        kdot_q[i]  <= DOT_W'(dot_q[i][0]) + DOT_W'(dot_q[i][1]) + DOT_W'(dot_q[i][2]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      for (int i = 0; i < 3; i++) begin
        hit_q[i]  <= dist2_q[i] <= r2_ext;
        exc_q[i]  <= dist2_q[i] - r2_ext;
        kv_q[i]   <= (kdot_q[i] > 0) && (kdot_q[i] < $signed(DOT_W'(len3_q[i])));
        len4_q[i] <= len3_q[i];
        k4_q[i]   <= kdot_q[i][SUM_W-1:0];
      end
    end
  end

  assign excess_o = exc_q;
  assign len_o    = len4_q;
  assign k_o      = k4_q;
  assign hit_o    = hit_q;
  assign kv_o     = kv_q;

endmodule

/* hw/rtl/tsc_wmul.sv */
// Three-stage wide unsigned multiplier built from four half-width partial products.
module tsc_wmul import tsc_pkg::*; (
  input  logic              clk_i,
  input  tsc_mul_en_t       en_i,
  input  logic [SUM_W-1:0]  a_i,
  input  logic [SUM_W-1:0]  b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [2*HALF_W-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [2*HALF_W-1:0] llb_q, hhb_q;
  logic [2*HALF_W:0]   cross_q;
  logic [PROD_W-1:0]   p_q;

  always_ff @(posedge clk_i) begin
    if (en_i.sa) begin
      ll_q <= a_i[HALF_W-1:0]      * b_i[HALF_W-1:0];
      lh_q <= a_i[HALF_W-1:0]      * b_i[SUM_W-1:HALF_W];
      hl_q <= a_i[SUM_W-1:HALF_W]  * b_i[HALF_W-1:0];
      hh_q <= a_i[SUM_W-1:HALF_W]  * b_i[SUM_W-1:HALF_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sb) begin
      cross_q <= (2*HALF_W+1)'(lh_q) + (2*HALF_W+1)'(hl_q);
      llb_q   <= ll_q;
      hhb_q   <= hh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sc) begin
      p_q <= {hhb_q, llb_q} + (PROD_W'(cross_q) << HALF_W);
    end
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/triangle_sphere_classify.sv */
// Top level of the triangle/sphere classifier.
// Accepts one triangle per clock unless backpressure stalls the input, and
// presents its class (0 outside, 1 crossing, 2 inside) on the output through an
// eight-stage pipeline: offsets and edges, exact squares and dot products,
// sums, vertex and projection tests, three stages of wide multiplication for
// the closest approach test, and the output register. Each stage holds its
// item only while the stage after it is full and stalled, so bubbles close up
// under backpressure. The sphere is set over an APB port (centre x, y, z and
// radius at byte addresses 0, 4, 8 and 12); write it only while no triangle is
// in flight.
module triangle_sphere_classify import tsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  tsc_in_if.sink             in_i,
  tsc_out_if.source          out_o
);

  logic [NUM_STAGES:1] vld_q, vld_in, rdy;
  tsc_coord_t          p [3][3];
  tsc_coord_t          ctr [3];
  logic [R2_W-1:0]     r2;
  tsc_front_en_t       front_en;
  tsc_mul_en_t         mul_en;
  logic [SUM_W-1:0]    excess [3];
  logic [SUM_W-1:0]    len [3];
  logic [SUM_W-1:0]    kval [3];
  logic [2:0]          hit, kv;
  logic [PROD_W-1:0]   ep [3];
  logic [PROD_W-1:0]   kk [3];
  logic [2:0]          hit5_q, hit6_q, hit7_q;
  logic [2:0]          kv5_q, kv6_q, kv7_q;
  logic [2:0]          edge_hit;
  tsc_class_e          class_d, class_q;

  tsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctr_o   (ctr),
    .r2_o    (r2)
  );

  always_comb begin
    rdy[NUM_STAGES] = !vld_q[NUM_STAGES] || out_o.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld_q[NUM_STAGES-1:1], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_i.ready = rdy[1];

  assign p[0][0] = in_i.v0_x;
  assign p[0][1] = in_i.v0_y;
  assign p[0][2] = in_i.v0_z;
  assign p[1][0] = in_i.v1_x;
  assign p[1][1] = in_i.v1_y;
  assign p[1][2] = in_i.v1_z;
  assign p[2][0] = in_i.v2_x;
  assign p[2][1] = in_i.v2_y;
  assign p[2][2] = in_i.v2_z;

  assign front_en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4]};
  assign mul_en   = '{sa: rdy[5], sb: rdy[6], sc: rdy[7]};

  tsc_front u_front (
    .clk_i    (clk_i),
    .en_i     (front_en),
    .p_i      (p),
    .ctr_i    (ctr),
    .r2_i     (r2),
    .excess_o (excess),
    .len_o    (len),
    .k_o      (kval),
    .hit_o    (hit),
    .kv_o     (kv)
  );

  for (genvar g = 0; g < 3; g++) begin : g_edge
    tsc_wmul u_mul_ex (
      .clk_i (clk_i),
      .en_i  (mul_en),
      .a_i   (excess[g]),
      .b_i   (len[g]),
      .p_o   (ep[g])
    );
    tsc_wmul u_mul_kk (
      .clk_i (clk_i),
      .en_i  (mul_en),
      .a_i   (kval[g]),
      .b_i   (kval[g]),
      .p_o   (kk[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      hit5_q <= hit;
      kv5_q  <= kv;
    end
    if (rdy[6]) begin
      hit6_q <= hit5_q;
      kv6_q  <= kv5_q;
    end
    if (rdy[7]) begin
      hit7_q <= hit6_q;
      kv7_q  <= kv6_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      edge_hit[i] = kv7_q[i] && (ep[i] <= kk[i]);
    end
    if (&hit7_q) begin
      class_d = CLASS_INSIDE;
    end else if (|hit7_q || |edge_hit) begin
      class_d = CLASS_CROSSING;
    end else begin
      class_d = CLASS_OUTSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      class_q <= class_d;
    end
  end

  assign out_o.valid          = vld_q[NUM_STAGES];
  assign out_o.coverage_class = class_q;

endmodule

/* tb/tsc_checker.sv */
// Checker for the triangle/sphere classifier: tracks the sphere, predicts each class and compares.
`timescale 1ns / 1ps

module tsc_checker import tsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  tsc_in_if                  tri_mon_i,
  tsc_out_if                 cls_mon_i,
  output int                 classes_due_o,
  output int                 mismatch_count_o
);

  typedef logic signed [79:0] exact_t;

  tsc_coord_t       centre_x;
  tsc_coord_t       centre_y;
  tsc_coord_t       centre_z;
  logic [RAD_W-1:0] radius;
  tsc_class_e       class_expected[$];
  tsc_class_e       oldest_class;

  function automatic tsc_class_e classify_triangle(input logic [143:0] tri_bits);
    exact_t pt[3][3];
    exact_t off[3][3];
    exact_t ctr[3];
    exact_t excess[3];
    exact_t edge_v;
    exact_t rad;
    exact_t rad_sq;
    exact_t dist_sq;
    exact_t dot;
    exact_t len_sq;
    int     inside_cnt;
    int     i;
    int     a;
    inside_cnt = 0;
    ctr[0] = centre_x;
    ctr[1] = centre_y;
    ctr[2] = centre_z;
    rad = radius;
    rad_sq = rad * rad;
    for (i = 0; i < 3; i++) begin
      for (a = 0; a < 3; a++) begin
        pt[i][a] = $signed(tri_bits[16*(3*i+a) +: 16]);
      end
    end
    for (i = 0; i < 3; i++) begin
      dist_sq = 0;
      for (a = 0; a < 3; a++) begin
        off[i][a] = ctr[a] - pt[i][a];
        dist_sq = dist_sq + off[i][a] * off[i][a];
      end
      if (dist_sq <= rad_sq) begin
        inside_cnt++;
        excess[i] = 0;
      end else begin
        excess[i] = dist_sq - rad_sq;
      end
    end
    if (inside_cnt == 3) return CLASS_INSIDE;
    if (inside_cnt > 0) return CLASS_CROSSING;
    // edge i runs from vertex i to vertex i+1, seen from vertex i
    for (i = 0; i < 3; i++) begin
      dot = 0;
      len_sq = 0;
      for (a = 0; a < 3; a++) begin
        edge_v = pt[(i+1)%3][a] - pt[i][a];
        dot = dot + edge_v * off[i][a];
        len_sq = len_sq + edge_v * edge_v;
      end
      if (dot > 0 && dot < len_sq && excess[i] * len_sq <= dot * dot) return CLASS_CROSSING;
    end
    return CLASS_OUTSIDE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x         <= '0;
      centre_y         <= '0;
      centre_z         <= '0;
      radius           <= RADIUS_RESET;
      class_expected.delete();
      classes_due_o    <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (tsc_reg_e'(paddr[3:2]))
          REG_CENTER_X: centre_x <= tsc_coord_t'(pwdata[COORD_WIDTH-1:0]);
          REG_CENTER_Y: centre_y <= tsc_coord_t'(pwdata[COORD_WIDTH-1:0]);
          REG_CENTER_Z: centre_z <= tsc_coord_t'(pwdata[COORD_WIDTH-1:0]);
          REG_RADIUS:   radius   <= pwdata[RAD_W-1:0];
          default: ;
        endcase
      end
      if (cls_mon_i.valid && cls_mon_i.ready) begin
        if (class_expected.size() == 0) begin
          $display("%0t: class %0d transferred with no triangle outstanding",
                   $time, cls_mon_i.coverage_class);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          oldest_class = class_expected.pop_front();
          if (cls_mon_i.coverage_class !== oldest_class) begin
            $display("%0t: coverage_class mismatch: expected %0d, actual %0d",
                     $time, oldest_class, cls_mon_i.coverage_class);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (tri_mon_i.valid && tri_mon_i.ready) begin
        class_expected.insert(class_expected.size(), classify_triangle({
          tri_mon_i.v2_z, tri_mon_i.v2_y, tri_mon_i.v2_x,
          tri_mon_i.v1_z, tri_mon_i.v1_y, tri_mon_i.v1_x,
          tri_mon_i.v0_z, tri_mon_i.v0_y, tri_mon_i.v0_x}));
      end
      classes_due_o <= class_expected.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the triangle/sphere classifier: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top import tsc_pkg::*; ();

  localparam int PHASE_ITEMS  = 230;
  localparam int IDLE_LIMIT   = 4000;
  localparam int PIPE_SETTLE  = NUM_STAGES + 4;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_BURSTY
  } sink_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int                 classes_due;
  int                 mismatch_count;

  logic [143:0]       tri_backlog[$];
  logic [143:0]       next_tri;
  int                 burst_left;
  int                 gap_left;
  sink_mode_e         sink_mode;
  int                 mode_left;
  int                 stall_left;
  int                 quiet_cycles = 0;
  int                 cfg_c[3];
  int                 cfg_r;
  int                 ph;

  tsc_in_if  tri_if ();
  tsc_out_if cls_if ();

  triangle_sphere_classify uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (tri_if),
    .out_o   (cls_if)
  );

  tsc_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .tri_mon_i        (tri_if),
    .cls_mon_i        (cls_if),
    .classes_due_o    (classes_due),
    .mismatch_count_o (mismatch_count)
  );

  always #5 clk_i = ~clk_i;

  function automatic int clamp_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int spread(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      6: return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic logic [143:0] gen_triangle();
    int           v[3][3];
    int           mid;
    int           s;
    int           first;
    int           ax;
    int           dlt;
    int           pick;
    int           i;
    int           a;
    logic [143:0] bits;
    pick = $urandom_range(0, 99);
    first = $urandom_range(0, 2);
    for (i = 0; i < 3; i++) begin
      ax = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0: dlt = 0;
        1: dlt = cfg_r + 1;
        default: dlt = cfg_r;
      endcase
      if ($urandom_range(0, 1) == 1) dlt = -dlt;
      for (a = 0; a < 3; a++) begin
        if (pick < 15) begin
          v[i][a] = int'($urandom_range(0, 65535)) - 32768;
        end else if (pick < 45 || pick >= 80 && pick < 90) begin
          v[i][a] = cfg_c[a] + spread(2 * cfg_r + 64);
        end else if (pick < 70) begin
          v[i][a] = cfg_c[a] + spread(32767);
        end else if (pick < 80) begin
          v[i][a] = cfg_c[a] + ((a == ax) ? dlt : 0);
        end else begin
          v[i][a] = extreme_coord();
        end
      end
    end
    if (pick >= 45 && pick < 70) begin
      for (a = 0; a < 3; a++) begin
        mid = cfg_c[a] + spread(cfg_r + 16);
        s = spread(3 * cfg_r + 100);
        v[first][a] = mid + s;
        v[(first+1)%3][a] = mid - s;
      end
    end
    if (pick >= 80 && pick < 90) begin
      v[1] = v[0];
      if ($urandom_range(0, 1) == 1) v[2] = v[0];
    end
    for (i = 0; i < 3; i++) begin
      for (a = 0; a < 3; a++) begin
        bits[16*(3*i+a) +: 16] = 16'(clamp_coord(v[i][a]));
      end
    end
    return bits;
  endfunction

  task automatic queue_triangle(input int ax, input int ay, input int az,
                                input int bx, input int by, input int bz,
                                input int cx, input int cy, input int cz);
    tri_backlog.insert(tri_backlog.size(),
                       {16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by), 16'(bx),
                        16'(az), 16'(ay), 16'(ax)});
  endtask

  task automatic queue_random(input int n);
    repeat (n) tri_backlog.insert(tri_backlog.size(), gen_triangle());
  endtask

  task automatic wait_drained();
    while (tri_backlog.size() != 0 || tri_if.valid || classes_due != 0) @(negedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(input tsc_reg_e idx, input int value);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    if (idx == REG_RADIUS) word[RAD_W-1:0] = value[RAD_W-1:0];
    else word[COORD_WIDTH-1:0] = value[COORD_WIDTH-1:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_sphere(input int cx, input int cy, input int cz, input int r);
    cfg_c[0] = cx;
    cfg_c[1] = cy;
    cfg_c[2] = cz;
    cfg_r = r;
    apb_write(REG_CENTER_X, cx);
    apb_write(REG_CENTER_Y, cy);
    apb_write(REG_CENTER_Z, cz);
    apb_write(REG_RADIUS, r);
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_if.valid <= 1'b0;
      tri_if.v0_x  <= '0;
      tri_if.v0_y  <= '0;
      tri_if.v0_z  <= '0;
      tri_if.v1_x  <= '0;
      tri_if.v1_y  <= '0;
      tri_if.v1_z  <= '0;
      tri_if.v2_x  <= '0;
      tri_if.v2_y  <= '0;
      tri_if.v2_z  <= '0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else if (!tri_if.valid || tri_if.ready) begin
      if (gap_left > 0) begin
        gap_left     <= gap_left - 1;
        tri_if.valid <= 1'b0;
      end else if (tri_backlog.size() != 0) begin
        next_tri = tri_backlog.pop_front();
        tri_if.valid <= 1'b1;
        tri_if.v0_x  <= next_tri[15:0];
        tri_if.v0_y  <= next_tri[31:16];
        tri_if.v0_z  <= next_tri[47:32];
        tri_if.v1_x  <= next_tri[63:48];
        tri_if.v1_y  <= next_tri[79:64];
        tri_if.v1_z  <= next_tri[95:80];
        tri_if.v2_x  <= next_tri[111:96];
        tri_if.v2_y  <= next_tri[127:112];
        tri_if.v2_z  <= next_tri[143:128];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        tri_if.valid <= 1'b0;
      end
    end
  end

  // receiver: switch between open, coin-toss and long-stall patterns
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_if.ready <= 1'b0;
      sink_mode    <= SINK_OPEN;
      mode_left    <= 0;
      stall_left   <= 0;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 2));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        SINK_OPEN: cls_if.ready <= 1'b1;
        SINK_COIN: cls_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            cls_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
          end else begin
            cls_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(4, 24);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((tri_if.valid && tri_if.ready) || (cls_if.valid && cls_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cfg_c[0] = 0;
    cfg_c[1] = 0;
    cfg_c[2] = 0;
    cfg_r = 4096;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sphere: radius 4096 at the origin
    queue_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_triangle(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_triangle(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    queue_triangle(4096, 0, 0, 0, 4096, 0, 0, 0, -4096);
    queue_triangle(4097, 0, 0, 0, 4096, 0, 0, 0, 4096);
    queue_triangle(0, 0, 0, 32767, 32767, 32767, -32768, -32768, -32768);
    queue_triangle(100, -100, 50, -4000, 0, 0, 30000, 0, 0);
    queue_triangle(-20000, 0, 0, 20000, 0, 0, 20000, 20000, 0);
    queue_triangle(20000, 20000, 0, -20000, 100, 0, 20000, 100, 0);
    queue_triangle(20000, -50, 0, 20000, 20000, 20000, -20000, -50, 0);
    queue_triangle(-8192, 4096, 0, 8192, 4096, 0, 8192, 20000, 20000);
    queue_triangle(-8192, 4097, 0, 8192, 4097, 0, 8192, 20000, 20000);
    queue_triangle(5000, 0, 0, 10000, 0, 0, 10000, 10000, 0);
    queue_triangle(8000, 0, 0, 8000, 0, 0, 8000, 0, 0);
    queue_triangle(8000, 0, 0, 8000, 0, 0, -8000, 0, 0);
    queue_triangle(-30000, -10000, 0, 30000, -10000, 0, 0, 30000, 0);
    queue_triangle(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
    queue_triangle(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, -32768);
    queue_triangle(21845, -21846, 21845, -21846, 21845, -21846, 1, -1, 0);
    wait_drained();

    set_sphere(-32768, -32768, -32768, 32767);
    queue_random(PHASE_ITEMS);
    wait_drained();

    set_sphere(32767, 32767, 32767, 0);
    queue_triangle(32767, 32767, 32767, 0, 0, 0, -32768, -32768, -32768);
    queue_triangle(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_random(PHASE_ITEMS);
    wait_drained();

    set_sphere(0, 0, 0, 0);
    queue_triangle(-100, 0, 0, 100, 0, 0, 100, 100, 0);
    queue_triangle(-100, 1, 0, 100, 1, 0, 100, 100, 0);
    queue_random(PHASE_ITEMS);
    wait_drained();

    for (ph = 0; ph < 5; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        cfg_c[0] = int'($urandom_range(0, 65535)) - 32768;
        cfg_c[1] = int'($urandom_range(0, 65535)) - 32768;
        cfg_c[2] = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        cfg_c[0] = spread(12000);
        cfg_c[1] = spread(12000);
        cfg_c[2] = spread(12000);
      end
      case ($urandom_range(0, 2))
        0: cfg_r = $urandom_range(0, 300);
        1: cfg_r = $urandom_range(1000, 8000);
        default: cfg_r = $urandom_range(8000, 32767);
      endcase
      set_sphere(cfg_c[0], cfg_c[1], cfg_c[2], cfg_r);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_if.sv
hw/rtl/tsc_cfg.sv
hw/rtl/tsc_front.sv
hw/rtl/tsc_wmul.sv
hw/rtl/triangle_sphere_classify.sv
tb/tsc_checker.sv
tb/tb_top.sv
